>>> rtl/snf_pkg.sv
// Shared types, constants and helper functions of the fractal simplex noise block.
package snf_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int MAX_OCTAVES = 8;
  localparam int IN_DEPTH   = 4;
  localparam int OUT_DEPTH  = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REG_OCTAVES = 2'd0;
  localparam logic [1:0] REG_PERSIST = 2'd1;

  localparam logic [3:0]  OCTAVES_RST = 4'd5;
  localparam logic [15:0] PERSIST_RST = 16'd32768;

  localparam logic [30:0] F2_Q32 = 31'd1572067139;
  localparam logic [29:0] G2_Q32 = 30'd907633386;
  localparam logic signed [35:0] G2_FX  = 36'sd13849;
  localparam logic signed [35:0] G2_FX2 = 36'sd27698;
  localparam logic signed [35:0] ONE_FX = 36'sd65536;
  localparam logic signed [37:0] R_HALF = 38'sd2147483648;
  localparam logic [16:0] AMP_ONE = 17'd65536;
  localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
  localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

  typedef struct packed {
    logic               is_eval;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         val;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } item_t;

  // value mod 12 by reciprocal multiply, exact for 8-bit values
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = 16'(v) * 16'd171;
    q = p[15:11];
    r = v - 8'(8'(q) * 8'd12);
    return r[3:0];
  endfunction

  function automatic logic signed [18:0] grad_dot(input logic [3:0] g,
                                                  input logic signed [17:0] dx,
                                                  input logic signed [17:0] dy);
    logic signed [18:0] ex;
    logic signed [18:0] ey;
    logic signed [18:0] d;
    ex = 19'(dx);
    ey = 19'(dy);
    unique case (g)
      4'd0:          d = -ex - ey;
      4'd1:          d = -ex + ey;
      4'd2:          d = ex - ey;
      4'd3:          d = ex + ey;
      4'd4, 4'd5:    d = -ex;
      4'd6, 4'd7:    d = ex;
      4'd8, 4'd9:    d = -ey;
      4'd10, 4'd11:  d = ey;
      default:       d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/simplex_noise_2d_fractal_top.sv
// Top level of the fractal 2D simplex noise block.
// Input channel: push/full queue. opcode 0 loads one permutation entry
// (table_index, table_value); opcode 1 evaluates noise at (coord_x, coord_y),
// signed Q16.16. Items are queued four deep ahead of the datapath.
// Result channel: empty/pop queue, two deep, one noise_value (Q8.16,
// saturated) per evaluate; loads give none.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 is
// octave_count, 1 is persistence; other indexes are ignored.
// Timing: loads can follow back to back. An evaluate issues one octave per
// cycle into an 11-stage datapath, and no further item leaves the input
// queue until its result has reached the result queue, so the block does
// not take a new item while an evaluate is in flight. An evaluate waits
// to start while the result queue is full, so a stalled receiver backs up
// the result queue, then the input queue, and full rises.
// Reset: queues empty, octave_count 5, persistence 0.5. The permutation
// table is not cleared and must be loaded before any evaluate.
module simplex_noise_2d_fractal_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_opcode,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_table_value,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [23:0] out_noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [3:0]         octave_count_r;
  logic [15:0]        persistence_r;
  logic               f_vld, f_take, oq_full, res_vld;
  snf_pkg::item_t     f_item;
  logic signed [23:0] res_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= snf_pkg::OCTAVES_RST;
      persistence_r  <= snf_pkg::PERSIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        snf_pkg::REG_OCTAVES: octave_count_r <= cfg_data[3:0];
        snf_pkg::REG_PERSIST: persistence_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  snf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .f_vld          (f_vld),
    .f_item         (f_item),
    .f_take         (f_take)
  );

  snf_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .octave_count (octave_count_r),
    .persistence  (persistence_r),
    .f_vld        (f_vld),
    .f_item       (f_item),
    .f_take       (f_take),
    .oq_full      (oq_full),
    .res_vld      (res_vld),
    .res_value    (res_value)
  );

  snf_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_vld         (res_vld),
    .res_value       (res_value),
    .oq_full         (oq_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_noise_value (out_noise_value)
  );

endmodule

>>> rtl/snf_front.sv
// Input queue that accepts and classifies load and evaluate items.
module snf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_opcode,
  input  logic [7:0]                  in_table_index,
  input  logic [7:0]                  in_table_value,
  input  logic signed [31:0]          in_coord_x,
  input  logic signed [31:0]          in_coord_y,
  output logic                        f_vld,
  output snf_pkg::item_t              f_item,
  input  logic                        f_take
);

  localparam int PW = $clog2(snf_pkg::IN_DEPTH);

  snf_pkg::item_t     q_r [snf_pkg::IN_DEPTH];
  logic [PW-1:0]      wr_r, rd_r;
  logic [PW:0]        cnt_r;
  logic               wr_en, rd_en;
  snf_pkg::item_t     item;

  assign in_full = (cnt_r == (PW+1)'(snf_pkg::IN_DEPTH));
  assign f_vld   = (cnt_r != '0);
  assign f_item  = q_r[rd_r];
  assign wr_en   = in_push && !in_full;
  assign rd_en   = f_take && f_vld;

  always_comb begin
    item.is_eval = (in_opcode == snf_pkg::OP_EVAL);
    item.idx     = in_table_index;
    item.val     = in_table_value;
    item.x       = in_coord_x;
    item.y       = in_coord_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wr_r <= wr_r + 1'b1;
      if (rd_en) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_r[wr_r] <= item;
  end

endmodule

>>> rtl/snf_core.sv
// Octave sequencer, permutation memories and pipelined simplex noise datapath.
module snf_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         octave_count,
  input  logic [15:0]        persistence,
  input  logic               f_vld,
  input  snf_pkg::item_t     f_item,
  output logic               f_take,
  input  logic               oq_full,
  output logic               res_vld,
  output logic signed [23:0] res_value
);

  localparam int NST = 11;

  // sequencer
  logic               busy_r, iss_r;
  logic [2:0]         k_r, nlast_r;
  logic signed [31:0] xs_r, ys_r;
  logic [16:0]        amp_r;
  logic [3:0]         n_cl;
  logic               start, do_load, iss_last;
  logic [32:0]        amp_prod;

  logic [NST-1:0]     vld_r, last_r;
  logic [16:0]        amp_pipe_r [NST-1];

  // memories
  logic [7:0]         perm_mem [snf_pkg::TABLE_SIZE];
  logic [3:0]         m12a_mem [snf_pkg::TABLE_SIZE];
  logic [3:0]         m12b_mem [snf_pkg::TABLE_SIZE];

  // stage registers
  logic signed [31:0] a_x_r, a_y_r;
  logic signed [32:0] a_s_r;
  logic signed [31:0] b_x_r, b_y_r;
  logic signed [17:0] b_ci_r, b_cj_r;
  logic signed [31:0] c_x_r, c_y_r;
  logic signed [17:0] c_ci_r, c_cj_r;
  logic signed [33:0] c_t_r;
  logic [7:0]         c_p0_r, c_p1_r;
  logic signed [35:0] d_x0_r, d_y0_r;
  logic               d_i1_r;
  logic [7:0]         d_ii_r, d_p0_r, d_p1_r;
  logic signed [17:0] e_dx_r [3];
  logic signed [17:0] e_dy_r [3];
  logic [2:0]         e_far_r;
  logic [3:0]         e_g_r [3];
  logic [15:0]        f_r1_r [3];
  logic signed [18:0] f_dot_r [3];
  logic [14:0]        g_r2_r [3];
  logic signed [18:0] g_dot_r [3];
  logic [12:0]        h_r4_r [3];
  logic signed [18:0] h_dot_r [3];
  logic signed [32:0] i_c_r [3];
  logic signed [25:0] j_nv_r;
  logic signed [27:0] k_ctb_r;
  logic signed [31:0] total_r;

  // combinational
  logic signed [32:0] sxy;
  logic signed [64:0] prod_a;
  logic signed [33:0] sx_b, sy_b;
  logic signed [18:0] csum;
  logic signed [49:0] prod_c;
  logic signed [35:0] x0, y0;
  logic signed [35:0] cx [3];
  logic signed [35:0] cy [3];
  logic [7:0]         adr0, adra, adrb;
  logic signed [35:0] sqx [3];
  logic signed [35:0] sqy [3];
  logic signed [37:0] rr [3];
  logic [31:0]        p2 [3];
  logic [29:0]        p4 [3];
  logic signed [32:0] cp [3];
  logic signed [34:0] csum3;
  logic signed [41:0] pn;
  logic signed [43:0] pk;
  logic signed [31:0] tot;

  always_comb begin
    priority if (octave_count == 4'd0) n_cl = 4'd1;
    else if (octave_count > 4'(snf_pkg::MAX_OCTAVES)) n_cl = 4'(snf_pkg::MAX_OCTAVES);
    else n_cl = octave_count;
  end

  assign start    = f_vld && !busy_r && (!f_item.is_eval || !oq_full);
  assign f_take   = start;
  assign do_load  = start && !f_item.is_eval;
  assign iss_last = iss_r && (k_r == nlast_r);
  assign amp_prod = 33'(amp_r) * 33'(persistence);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      iss_r   <= 1'b0;
      k_r     <= '0;
      nlast_r <= '0;
      vld_r   <= '0;
      last_r  <= '0;
      total_r <= '0;
    end else begin
      vld_r  <= {vld_r[NST-2:0], iss_r};
      last_r <= {last_r[NST-2:0], iss_last};
      if (start && f_item.is_eval) begin
        busy_r  <= 1'b1;
        iss_r   <= 1'b1;
        k_r     <= '0;
        nlast_r <= 3'(n_cl - 4'd1);
      end else begin
        if (iss_r) begin
          k_r <= k_r + 3'd1;
          if (iss_last) iss_r <= 1'b0;
        end
        if (res_vld) busy_r <= 1'b0;
      end
      if (vld_r[NST-1]) total_r <= last_r[NST-1] ? '0 : tot;
    end
  end

  always_ff @(posedge clk) begin
    if (start && f_item.is_eval) begin
      xs_r  <= f_item.x;
      ys_r  <= f_item.y;
      amp_r <= snf_pkg::AMP_ONE;
    end else begin
      xs_r  <= xs_r <<< 1;
      ys_r  <= ys_r <<< 1;
      amp_r <= amp_prod[32:16];
    end
    amp_pipe_r[0] <= amp_r;
    for (int i = 1; i < NST-1; i++) amp_pipe_r[i] <= amp_pipe_r[i-1];
  end

  // stage A: skew factor
  always_comb begin
    sxy    = 33'(xs_r) + 33'(ys_r);
    prod_a = sxy * $signed({1'b0, snf_pkg::F2_Q32});
  end

  always_ff @(posedge clk) begin
    a_x_r <= xs_r;
    a_y_r <= ys_r;
    a_s_r <= prod_a[64:32];
  end

  // stage B: cell
  always_comb begin
    sx_b = 34'(a_x_r) + 34'(a_s_r);
    sy_b = 34'(a_y_r) + 34'(a_s_r);
  end

  always_ff @(posedge clk) begin
    b_x_r  <= a_x_r;
    b_y_r  <= a_y_r;
    b_ci_r <= sx_b[33:16];
    b_cj_r <= sy_b[33:16];
  end

  // stage C: unskew and permutation reads
  always_comb begin
    csum   = 19'(b_ci_r) + 19'(b_cj_r);
    prod_c = csum * $signed({1'b0, snf_pkg::G2_Q32});
  end

  always_ff @(posedge clk) begin
    c_x_r  <= b_x_r;
    c_y_r  <= b_y_r;
    c_ci_r <= b_ci_r;
    c_cj_r <= b_cj_r;
    c_t_r  <= prod_c[49:16];
    c_p0_r <= perm_mem[b_cj_r[7:0]];
    c_p1_r <= perm_mem[b_cj_r[7:0] + 8'd1];
    if (do_load) perm_mem[f_item.idx] <= f_item.val;
  end

  // stage D: first corner offset and corner order
  always_comb begin
    x0 = 36'(c_x_r) - (36'(c_ci_r) <<< 16) + 36'(c_t_r);
    y0 = 36'(c_y_r) - (36'(c_cj_r) <<< 16) + 36'(c_t_r);
  end

  always_ff @(posedge clk) begin
    d_x0_r <= x0;
    d_y0_r <= y0;
    d_i1_r <= (x0 > y0);
    d_ii_r <= c_ci_r[7:0];
    d_p0_r <= c_p0_r;
    d_p1_r <= c_p1_r;
  end

  // stage E: corner offsets and gradient reads
  always_comb begin
    cx[0] = d_x0_r;
    cy[0] = d_y0_r;
    cx[1] = d_x0_r - (d_i1_r ? snf_pkg::ONE_FX : '0) + snf_pkg::G2_FX;
    cy[1] = d_y0_r - (d_i1_r ? '0 : snf_pkg::ONE_FX) + snf_pkg::G2_FX;
    cx[2] = d_x0_r - snf_pkg::ONE_FX + snf_pkg::G2_FX2;
    cy[2] = d_y0_r - snf_pkg::ONE_FX + snf_pkg::G2_FX2;
    adr0  = d_ii_r + d_p0_r;
    adra  = d_ii_r + 8'(d_i1_r) + (d_i1_r ? d_p0_r : d_p1_r);
    adrb  = d_ii_r + 8'd1 + d_p1_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e_dx_r[i]  <= cx[i][17:0];
      e_dy_r[i]  <= cy[i][17:0];
      e_far_r[i] <= !((cx[i][35:17] == '0) || (cx[i][35:17] == '1)) ||
                    !((cy[i][35:17] == '0) || (cy[i][35:17] == '1));
    end
    e_g_r[0] <= m12a_mem[adr0];
    e_g_r[1] <= m12a_mem[adra];
    e_g_r[2] <= m12b_mem[adrb];
    if (do_load) begin
      m12a_mem[f_item.idx] <= snf_pkg::mod12(f_item.val);
      m12b_mem[f_item.idx] <= snf_pkg::mod12(f_item.val);
    end
  end

  // stages F to I: falloff^4 times gradient dot, one lane per corner
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqx[i] = e_dx_r[i] * e_dx_r[i];
      sqy[i] = e_dy_r[i] * e_dy_r[i];
      rr[i]  = snf_pkg::R_HALF - 38'(sqx[i]) - 38'(sqy[i]);
      p2[i]  = 32'(f_r1_r[i]) * 32'(f_r1_r[i]);
      p4[i]  = 30'(g_r2_r[i]) * 30'(g_r2_r[i]);
      cp[i]  = $signed({1'b0, h_r4_r[i]}) * h_dot_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      f_r1_r[i]  <= (rr[i][37] || e_far_r[i]) ? '0 : rr[i][31:16];
      f_dot_r[i] <= snf_pkg::grad_dot(e_g_r[i], e_dx_r[i], e_dy_r[i]);
      g_r2_r[i]  <= p2[i][30:16];
      g_dot_r[i] <= f_dot_r[i];
      h_r4_r[i]  <= p4[i][28:16];
      h_dot_r[i] <= g_dot_r[i];
      i_c_r[i]   <= cp[i];
    end
  end

  // stages J, K: scale by 70, weight by amplitude; L: accumulate
  always_comb begin
    csum3 = 35'(i_c_r[0]) + 35'(i_c_r[1]) + 35'(i_c_r[2]);
    pn    = 42'(csum3) * 42'sd70;
    pk    = j_nv_r * $signed({1'b0, amp_pipe_r[NST-2]});
    tot   = total_r + 32'(k_ctb_r);
  end

  always_ff @(posedge clk) begin
    j_nv_r  <= pn[41:16];
    k_ctb_r <= pk[43:16];
  end

  assign res_vld = vld_r[NST-1] && last_r[NST-1];

  always_comb begin
    priority if (tot > snf_pkg::OUT_MAX) res_value = snf_pkg::OUT_MAX[23:0];
    else if (tot < snf_pkg::OUT_MIN) res_value = snf_pkg::OUT_MIN[23:0];
    else res_value = tot[23:0];
  end

endmodule

>>> rtl/snf_outq.sv
// Two-entry result queue between the datapath and the result channel.
module snf_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_vld,
  input  logic signed [23:0] res_value,
  output logic               oq_full,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [23:0] out_noise_value
);

  localparam int PW = $clog2(snf_pkg::OUT_DEPTH);

  logic signed [23:0] q_r [snf_pkg::OUT_DEPTH];
  logic [PW-1:0]      wr_r, rd_r;
  logic [PW:0]        cnt_r;
  logic               wr_en, rd_en;

  assign oq_full         = (cnt_r == (PW+1)'(snf_pkg::OUT_DEPTH));
  assign out_empty       = (cnt_r == '0);
  assign out_noise_value = q_r[rd_r];
  assign wr_en           = res_vld && !oq_full;
  assign rd_en           = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wr_r <= wr_r + 1'b1;
      if (rd_en) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_r[wr_r] <= res_value;
  end

endmodule

>>> rtl/snf_checker.sv
// Port-level checks of the fractal simplex noise block, bound to the top level.
module snf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [23:0] out_noise_value
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty ##1 out_empty)
    else $error("result present too soon after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_noise_value)))
    else $error("waiting result changed before transfer");

endmodule

bind simplex_noise_2d_fractal_top snf_checker u_snf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_noise_value (out_noise_value)
);

>>> test/simplex_noise_2d_fractal_top_tb.sv
// Self-checking testbench for the fractal simplex noise block: directed table plus random items.
`timescale 1ns / 100ps

module simplex_noise_2d_fractal_top_tb;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam longint SKEW_K   = 64'sd1572067139;
  localparam longint UNSKEW_K = 64'sd907633386;
  localparam int RAND_ITEMS = 582;
  localparam int PHASES = 6;

  typedef struct {
    logic               op;
    logic [7:0]         idx;
    logic [7:0]         val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 fixed;
    logic signed [23:0] want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic in_opcode;
  logic [7:0] in_table_index;
  logic [7:0] in_table_value;
  logic signed [31:0] in_coord_x;
  logic signed [31:0] in_coord_y;
  logic out_empty;
  logic out_pop;
  logic signed [23:0] out_noise_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  logic [7:0] perm_tab [256];
  logic [3:0] perm_m12 [256];
  logic [3:0] oct_reg;
  logic [15:0] pers_reg;
  logic signed [23:0] noise_q[$];
  int errors;
  int tx_idle;
  int rx_idle;
  bit hold_req;
  int hold_left;

  simplex_noise_2d_fractal_top DUT (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint corner_term(longint dx, longint dy, logic [3:0] g);
    longint r;
    longint r1;
    longint r2;
    longint r4;
    longint dot;
    r = (64'sd1 <<< 31) - dx * dx - dy * dy;
    if (r < 0) return 0;
    r1 = r >>> 16;
    r2 = (r1 * r1) >>> 16;
    r4 = (r2 * r2) >>> 16;
    case (g)
      4'd0: dot = -dx - dy;
      4'd1: dot = -dx + dy;
      4'd2: dot = dx - dy;
      4'd3: dot = dx + dy;
      4'd4, 4'd5: dot = -dx;
      4'd6, 4'd7: dot = dx;
      4'd8, 4'd9: dot = -dy;
      default: dot = dy;
    endcase
    return r4 * dot;
  endfunction

  function automatic longint octave_value(longint x, longint y);
    longint s, ci, cj, t, g2, x0, y0, i1, j1, ii, jj, sum;
    logic [3:0] g0, ga, gb;
    s  = ((x + y) * SKEW_K) >>> 32;
    ci = (x + s) >>> 16;
    cj = (y + s) >>> 16;
    t  = ((ci + cj) * UNSKEW_K) >>> 16;
    g2 = UNSKEW_K >>> 16;
    x0 = x - ci * 65536 + t;
    y0 = y - cj * 65536 + t;
    i1 = (x0 > y0) ? 1 : 0;
    j1 = 1 - i1;
    ii = ci & 255;
    jj = cj & 255;
    g0 = perm_m12[(ii + perm_tab[jj]) & 255];
    ga = perm_m12[(ii + i1 + perm_tab[(jj + j1) & 255]) & 255];
    gb = perm_m12[(ii + 1 + perm_tab[(jj + 1) & 255]) & 255];
    sum = corner_term(x0, y0, g0)
        + corner_term(x0 - i1 * 65536 + g2, y0 - j1 * 65536 + g2, ga)
        + corner_term(x0 - 65536 + 2 * g2, y0 - 65536 + 2 * g2, gb);
    return (70 * sum) >>> 16;
  endfunction

  function automatic logic signed [23:0] fractal_noise(logic signed [31:0] x,
                                                       logic signed [31:0] y);
    int n;
    longint amp;
    longint total;
    logic [31:0] wx;
    logic [31:0] wy;
    n = oct_reg;
    amp = 65536;
    total = 0;
    if (n == 0) n = 1;
    if (n > snf_pkg::MAX_OCTAVES) n = snf_pkg::MAX_OCTAVES;
    for (int k = 0; k < n; k++) begin
      wx = x << k;
      wy = y << k;
      total += (octave_value(longint'(signed'(wx)), longint'(signed'(wy))) * amp) >>> 16;
      amp = (amp * pers_reg) >> 16;
    end
    if (total > 8388607) total = 8388607;
    if (total < -8388608) total = -8388608;
    return total[23:0];
  endfunction

  task automatic report_mismatch(string what, logic signed [23:0] got,
                                 logic signed [23:0] want);
    errors++;
    $display("mismatch %s: noise_value got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic push_item(logic op, logic [7:0] idx, logic [7:0] val,
                           logic signed [31:0] x, logic signed [31:0] y,
                           bit fixed, logic signed [23:0] want);
    while ($urandom_range(99) < tx_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_opcode      <= op;
    in_table_index <= idx;
    in_table_value <= val;
    in_coord_x     <= x;
    in_coord_y     <= y;
    do @(posedge clk); while (in_full);
    if (op == snf_pkg::OP_EVAL) begin
      noise_q.push_back(fixed ? want : fractal_noise(x, y));
    end else begin
      perm_tab[idx] = val;
      perm_m12[idx] = 4'(val % 8'd12);
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == snf_pkg::REG_OCTAVES) oct_reg = data[3:0];
    else if (idx == snf_pkg::REG_PERSIST) pers_reg = data;
  endtask

  task automatic drain;
    in_push <= 1'b0;
    @(posedge clk);
    while (noise_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2097152)) - 32'sd1048576;
      2: return $signed($urandom_range(131072)) - 32'sd65536;
      default: return $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
                                        : 32'sh8000_0000 + $urandom_range(3);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (noise_q.size() == 0) begin
        errors++;
        $display("unexpected result %0d at %0t", out_noise_value, $realtime);
      end else begin
        logic signed [23:0] want;
        want = noise_q.pop_front();
        if (out_noise_value !== want) report_mismatch("result", out_noise_value, want);
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [7:0] shuffle [256];
    logic [7:0] tmp;
    int j;
    int op_pick;
    logic [3:0] oct_pick;

    rst_n = 1'b0;
    in_push = 1'b0;
    in_opcode = snf_pkg::OP_LOAD;
    in_table_index = '0;
    in_table_value = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = snf_pkg::REG_OCTAVES;
    cfg_data = '0;
    errors = 0;
    hold_req = 1'b0;
    hold_left = 0;
    tx_idle = 33;
    rx_idle = 50;
    oct_reg = snf_pkg::OCTAVES_RST;
    pers_reg = snf_pkg::PERSIST_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = shuffle[i];
      shuffle[i] = shuffle[j];
      shuffle[j] = tmp;
    end
    for (int i = 0; i < 256; i++)
      push_item(snf_pkg::OP_LOAD, 8'(i), shuffle[i], $urandom, $urandom, 0, '0);

    // origin lands on a corner with zero gradient distance; others fall outside
    rows.push_back('{snf_pkg::OP_EVAL, 8'hFF, 8'hFF, 32'sd0, 32'sd0, 1, 24'sd0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'h00, 8'h00, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'h00, 8'h00, 32'sh8000_0000, 32'sh8000_0000, 0, 0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'hA5, 8'h5A, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'h00, 8'h00, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'h00, 8'h00, 32'sh0001_8000, 32'sh0000_4000, 0, 0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'h00, 8'h00, 32'sh0000_4000, 32'sh0001_8000, 0, 0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'h00, 8'h00, -32'sh0002_3456, 32'sh0005_0001, 0, 0});
    rows.push_back('{snf_pkg::OP_LOAD, 8'h00, 8'hFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0});
    rows.push_back('{snf_pkg::OP_LOAD, 8'hFF, 8'h00, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'hFF, 8'hFF, 32'sh0000_8000, 32'sh0000_8000, 0, 0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'h00, 8'h00, -32'sh0000_0001, -32'sh0000_0001, 0, 0});
    rows.push_back('{snf_pkg::OP_EVAL, 8'h00, 8'h00, 32'sh00FF_0000, -32'sh00FF_0000, 0, 0});
    foreach (rows[i])
      push_item(rows[i].op, rows[i].idx, rows[i].val, rows[i].x, rows[i].y,
                rows[i].fixed, rows[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          cfg_write(snf_pkg::REG_OCTAVES, {12'($urandom_range(4095)), 4'd1});
          cfg_write(snf_pkg::REG_PERSIST, 16'h0000);
        end
        1: begin
          cfg_write(snf_pkg::REG_OCTAVES, {12'($urandom_range(4095)), 4'd8});
          cfg_write(snf_pkg::REG_PERSIST, 16'hFFFF);
        end
        2: begin
          cfg_write(snf_pkg::REG_OCTAVES, 16'h0000);
          cfg_write(snf_pkg::REG_PERSIST, 16'($urandom));
        end
        3: begin
          cfg_write(snf_pkg::REG_OCTAVES, 16'h000F);
          cfg_write(snf_pkg::REG_PERSIST, 16'($urandom));
          cfg_write(REG_SPARE_A, 16'($urandom));
          cfg_write(REG_SPARE_B, 16'($urandom));
        end
        default: begin
          oct_pick = 4'($urandom_range(snf_pkg::MAX_OCTAVES, 1));
          cfg_write(snf_pkg::REG_OCTAVES, {12'($urandom_range(4095)), oct_pick});
          cfg_write(snf_pkg::REG_PERSIST, 16'($urandom));
        end
      endcase
      cfg_valid <= 1'b0;
      @(posedge clk);
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        j = ph * (RAND_ITEMS / PHASES) + n;
        if (j < RAND_ITEMS / 3) begin
          tx_idle = 33;
          rx_idle = 50;
        end else if (j < 2 * RAND_ITEMS / 3) begin
          tx_idle = 50;
          rx_idle = 33;
        end else begin
          tx_idle = 0;
          rx_idle = 0;
        end
        op_pick = $urandom_range(99);
        if (op_pick < 25)
          push_item(snf_pkg::OP_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom,
                    0, '0);
        else
          push_item(snf_pkg::OP_EVAL, 8'($urandom), 8'($urandom), rand_coord(),
                    rand_coord(), 0, '0);
      end
    end

    in_push <= 1'b0;
    @(posedge clk);
    while (noise_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/snf_pkg.sv
rtl/snf_front.sv
rtl/snf_core.sv
rtl/snf_outq.sv
rtl/simplex_noise_2d_fractal_top.sv
rtl/snf_checker.sv
test/simplex_noise_2d_fractal_top_tb.sv
